>>> design/mit_pkg.sv
// Package for the multiple interval timer: command and response words,
// mode codes, sequencer states and the cell command bundle.
// No dependencies.
package mit_pkg;

    localparam int ID_W   = 3;
    localparam int SEC_W  = 16;
    localparam int REM_W  = 32;
    localparam int MODE_W = 3;

    // Command modes; codes 5..7 are no-ops.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_CHECK = 3'd3,
        MODE_QUERY = 3'd4
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   timer_id;
        logic [SEC_W-1:0]  seconds;
    } t_cmd_word;

    typedef struct packed {
        logic [ID_W-1:0]          expired_id;
        logic signed [REM_W-1:0]  remaining;
    } t_rsp_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Broadcast to every cell.
    typedef struct packed {
        logic            arm;     // load expiry and set armed on id match
        logic            disarm;  // clear armed and expiry on id match
        logic [ID_W-1:0] id;      // target of arm or disarm
        logic [ID_W-1:0] qid;     // timer whose state rides the scan word
    } t_cell_cmd;

endpackage

>>> design/mit_cell.sv
// One timer cell: armed bit and expiry, plus one stage of the scan chain.
// Depends on mit_pkg.
module mit_cell
    import mit_pkg::*;
#(
    parameter int TW      = 32,
    parameter int CELL_ID = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_cmd       i_cmd,
    input  logic [TW-1:0]   i_load,
    // scan word from the left neighbor
    input  logic            i_found,
    input  logic [ID_W-1:0] i_eid,
    input  logic [TW-1:0]   i_etime,
    input  logic            i_qarm,
    input  logic [TW-1:0]   i_qexp,
    // scan word to the right neighbor
    output logic            o_found,
    output logic [ID_W-1:0] o_eid,
    output logic [TW-1:0]   o_etime,
    output logic            o_qarm,
    output logic [TW-1:0]   o_qexp
);

    // Cells past the reach of the id field are never addressed.
    localparam bit             REACH  = CELL_ID < (1 << ID_W);
    localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_ID);

    logic          r_armed;
    logic [TW-1:0] r_exp;
    logic          w_hit;
    logic          w_qhit;
    logic          w_take;

    assign w_hit  = REACH && (i_cmd.id == MY_ID);
    assign w_qhit = REACH && (i_cmd.qid == MY_ID);
    // strict less-than keeps the lower id on a tie
    assign w_take = r_armed && (!i_found || (r_exp < i_etime));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_exp   <= '0;
        end else if (i_cmd.arm && w_hit) begin
            r_armed <= 1'b1;
            r_exp   <= i_load;
        end else if (i_cmd.disarm && w_hit) begin
            r_armed <= 1'b0;
            r_exp   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_found <= i_found | r_armed;
        o_eid   <= w_take ? MY_ID : i_eid;
        o_etime <= w_take ? r_exp : i_etime;
        o_qarm  <= w_qhit ? r_armed : i_qarm;
        o_qexp  <= w_qhit ? r_exp : i_qexp;
    end

endmodule

>>> design/multi_interval_timer.sv
// Top level of the multiple interval timer: sequencer, seconds counter,
// earliest-deadline registers and the row of mit_cell timers.
// Depends on mit_pkg and mit_cell.
//
// Usage: drive a command word on i_cmd with start high; it is taken at the
// first clock edge where busy is low. Every command gives exactly one
// response word on o_rsp, marked by o_done for one cycle; the receiver
// cannot hold it off, so o_rsp must be captured in that cycle. A command
// keeps busy high through the update state, the scan state, in which the
// scan word walks the cell row one registered stage per cell, and the
// done state; o_done rises the cycle busy falls. No new command is taken
// while busy is high, so the walk of the scan word through the cell row
// sets the command rate. Every command, tick included, takes the same
// path. Timer id 0 and ids at or above NUM_TIMERS address nothing. The
// earliest armed timer is rescanned on every command, so a restart of a
// running timer is always honored. Query answers the expiry minus the
// current time, wrapped to TIME_WIDTH bits, read as signed and clamped
// to 32 bits; 0 for an idle timer.
module multi_interval_timer
    import mit_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cmd_word i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_rsp_word o_rsp
);

    localparam int TW = TIME_WIDTH;
    localparam int CW = $clog2(NUM_TIMERS);
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_TIMERS - 1);

    t_state r_state;
    t_state n_state;

    t_cmd_word       r_cmd;
    logic [TW-1:0]   r_now;
    logic [ID_W-1:0] r_earliest_id;
    logic [TW-1:0]   r_earliest_time;
    logic [ID_W-1:0] r_found;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    t_rsp_word       r_rsp;

    t_cell_cmd w_cell_cmd;
    logic      w_id_ok;
    logic      w_hit;
    logic      w_accept;

    // scan chain taps; tap 0 is the empty word fed to the first cell
    logic            tk_found [0:NUM_TIMERS];
    logic [ID_W-1:0] tk_eid   [0:NUM_TIMERS];
    logic [TW-1:0]   tk_etime [0:NUM_TIMERS];
    logic            tk_qarm  [0:NUM_TIMERS];
    logic [TW-1:0]   tk_qexp  [0:NUM_TIMERS];

    assign w_accept = start && !busy;
    assign w_id_ok  = (r_cmd.timer_id != '0) && (int'(r_cmd.timer_id) < NUM_TIMERS);
    // check fires when the earliest deadline has been reached
    assign w_hit    = (r_earliest_id != '0) && (r_earliest_time <= r_now);

    // ---- sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_SCAN;
            ST_SCAN:   if (r_cnt == CNT_LAST) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs
    always_comb begin
        busy       = 1'b1;
        w_cell_cmd = '{arm: 1'b0, disarm: 1'b0, id: r_cmd.timer_id,
                       qid: r_cmd.timer_id};
        unique case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_UPDATE: begin
                if (r_cmd.mode == MODE_START) begin
                    w_cell_cmd.arm = w_id_ok;
                end else if (r_cmd.mode == MODE_STOP) begin
                    w_cell_cmd.disarm = w_id_ok;
                end else if (r_cmd.mode == MODE_CHECK) begin
                    w_cell_cmd.disarm = w_hit;
                    w_cell_cmd.id     = r_earliest_id;
                end
            end
            ST_SCAN, ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command hold
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
    end

    // seconds counter, check result, scan counter, earliest deadline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now           <= '0;
            r_earliest_id   <= '0;
            r_earliest_time <= '0;
            r_found         <= '0;
            r_cnt           <= '0;
        end else begin
            unique case (r_state)
                ST_UPDATE: begin
                    r_cnt   <= '0;
                    r_found <= ((r_cmd.mode == MODE_CHECK) && w_hit) ? r_earliest_id : '0;
                    if (r_cmd.mode == MODE_TICK) begin
                        r_now <= r_now + TW'(1);
                    end
                end
                ST_SCAN: r_cnt <= r_cnt + CW'(1);
                ST_DONE: begin
                    // bank state is unchanged except by start, stop and check,
                    // so taking the rescan on every command is exact
                    r_earliest_id   <= tk_found[NUM_TIMERS] ? tk_eid[NUM_TIMERS] : '0;
                    r_earliest_time <= tk_found[NUM_TIMERS] ? tk_etime[NUM_TIMERS] : '0;
                end
                default: ;
            endcase
        end
    end

    // ---- cell row
    assign tk_found[0] = 1'b0;
    assign tk_eid[0]   = '0;
    assign tk_etime[0] = '0;
    assign tk_qarm[0]  = 1'b0;
    assign tk_qexp[0]  = '0;

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
        mit_cell #(
            .TW      (TW),
            .CELL_ID (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cell_cmd),
            .i_load  (r_now + TW'(r_cmd.seconds)),
            .i_found (tk_found[k]),
            .i_eid   (tk_eid[k]),
            .i_etime (tk_etime[k]),
            .i_qarm  (tk_qarm[k]),
            .i_qexp  (tk_qexp[k]),
            .o_found (tk_found[k+1]),
            .o_eid   (tk_eid[k+1]),
            .o_etime (tk_etime[k+1]),
            .o_qarm  (tk_qarm[k+1]),
            .o_qexp  (tk_qexp[k+1])
        );
    end

    // ---- query arithmetic: wrapped difference, clamped to 32 bits signed
    logic [TW-1:0]    w_diff;
    logic [REM_W-1:0] w_left;

    assign w_diff = tk_qexp[NUM_TIMERS] - r_now;

    if (TW <= REM_W) begin : g_narrow
        assign w_left = REM_W'($signed(w_diff));
    end else begin : g_wide
        logic w_hi_ones;
        logic w_hi_zero;
        assign w_hi_ones = &w_diff[TW-1:REM_W-1];
        assign w_hi_zero = ~|w_diff[TW-1:REM_W-1];
        always_comb begin
            if (w_hi_ones || w_hi_zero) begin
                w_left = w_diff[REM_W-1:0];
            end else if (w_diff[TW-1]) begin
                w_left = {1'b1, {(REM_W-1){1'b0}}};
            end else begin
                w_left = {1'b0, {(REM_W-1){1'b1}}};
            end
        end
    end

    // ---- response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_rsp.expired_id <= r_found;
            r_rsp.remaining  <= ((r_cmd.mode == MODE_QUERY) && w_id_ok && tk_qarm[NUM_TIMERS])
                                ? w_left : '0;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

>>> design/mit_checker.sv
// Port-level checks for multi_interval_timer, bound to the top level.
// Depends on mit_pkg.
module mit_checker
    import mit_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_cmd_word i_cmd,
    input logic      busy,
    input logic      o_done,
    input t_rsp_word o_rsp
);

    // an accepted word always occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // one response per word: the strobe falls after each response word
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("response strobe held two cycles");

    // the response appears exactly as busy drops
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a response");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response while busy");

    // a word is either a check result or a query result, never both
    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.expired_id == '0 || o_rsp.remaining == '0))
        else $error("expired id and remaining both nonzero");

endmodule

bind multi_interval_timer mit_checker u_mit_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_cmd   (i_cmd),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

>>> sim/mit_checker.sv
// Response checker for multi_interval_timer: keeps its own copy of the timer
// bank, predicts one response word per accepted command and compares in order.
// Depends on mit_pkg.
`timescale 1ns / 1ps

module mit_resp_checker
    import mit_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_cmd_word i_cmd,
    input  logic      i_done,
    input  t_rsp_word i_rsp,
    output int        o_errors,
    output int        o_outstanding,
    output int        o_checked,
    output int        o_fired,
    output int        o_overdue
);

    localparam int     NO_TIMER   = 0;
    localparam int     REPORT_CAP = 30;
    localparam longint LEFT_MAX   = (longint'(1) << (REM_W - 1)) - 1;
    localparam longint LEFT_MIN   = -(longint'(1) << (REM_W - 1));

    logic [TIME_WIDTH-1:0] now_secs;
    logic [TIME_WIDTH-1:0] deadline [NUM_TIMERS];
    logic                  running  [NUM_TIMERS];
    t_rsp_word             rsp_due  [$];

    // Earliest running timer; strict compare keeps the lowest id on a tie.
    function automatic int soonest_timer();
        int best;
        best = NO_TIMER;
        for (int k = 1; k < NUM_TIMERS; k++) begin
            if (running[k] && (best == NO_TIMER || deadline[k] < deadline[best])) begin
                best = k;
            end
        end
        return best;
    endfunction

    // Expiry minus now, wrapped, read signed, clamped to the response width.
    function automatic logic signed [REM_W-1:0] secs_left(int id);
        logic signed [TIME_WIDTH-1:0] diff;
        longint                       wide;
        if (!running[id]) begin
            return '0;
        end
        diff = deadline[id] - now_secs;
        wide = diff;
        if (wide > LEFT_MAX) begin
            wide = LEFT_MAX;
        end else if (wide < LEFT_MIN) begin
            wide = LEFT_MIN;
        end
        return wide[REM_W-1:0];
    endfunction

    // Applies one command to the bank and returns the response it yields.
    function automatic t_rsp_word run_command(t_cmd_word c);
        t_rsp_word r;
        int        id;
        int        hit;
        logic      addressed;
        r         = '0;
        id        = c.timer_id;
        addressed = (id != NO_TIMER) && (id < NUM_TIMERS);
        case (c.mode)
            MODE_TICK: begin
                now_secs = now_secs + 1'b1;
            end
            MODE_START: begin
                if (addressed) begin
                    deadline[id] = now_secs + c.seconds;
                    running[id]  = 1'b1;
                end
            end
            MODE_STOP: begin
                if (addressed) begin
                    deadline[id] = '0;
                    running[id]  = 1'b0;
                end
            end
            MODE_CHECK: begin
                hit = soonest_timer();
                if (hit != NO_TIMER && deadline[hit] <= now_secs) begin
                    r.expired_id  = ID_W'(hit);
                    deadline[hit] = '0;
                    running[hit]  = 1'b0;
                end
            end
            MODE_QUERY: begin
                if (addressed) begin
                    r.remaining = secs_left(id);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp_word want;
        if (!i_rst_n) begin
            now_secs = '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                deadline[k] = '0;
                running[k]  = 1'b0;
            end
            rsp_due.delete();
            o_errors  = 0;
            o_checked = 0;
            o_fired   = 0;
            o_overdue = 0;
        end else begin
            // Response side first: it always belongs to an older command.
            if (i_done) begin
                if (rsp_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_CAP) begin
                        $error("response word with none pending: expired_id %0d remaining %0d",
                               i_rsp.expired_id, i_rsp.remaining);
                    end
                end else begin
                    want = rsp_due.pop_front();
                    o_checked++;
                    if (want.expired_id != 0) o_fired++;
                    if (want.remaining < 0) o_overdue++;
                    if (i_rsp.expired_id !== want.expired_id) begin
                        o_errors++;
                        if (o_errors <= REPORT_CAP) begin
                            $error("expired_id: expected %0d, got %0d",
                                   want.expired_id, i_rsp.expired_id);
                        end
                    end
                    if (i_rsp.remaining !== want.remaining) begin
                        o_errors++;
                        if (o_errors <= REPORT_CAP) begin
                            $error("remaining: expected %0d, got %0d",
                                   want.remaining, i_rsp.remaining);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                rsp_due.push_back(run_command(i_cmd));
            end
        end
        o_outstanding = rsp_due.size();
    end

endmodule

>>> sim/testbench.sv
// Top of the multi_interval_timer testbench: clock, reset, command stimulus
// and verdict. Depends on mit_pkg, multi_interval_timer and mit_resp_checker.
`timescale 1ns / 1ps

module testbench;
    import mit_pkg::*;

    localparam int NUM_TIMERS   = 8;
    localparam int TIME_WIDTH   = 32;
    // Settling wait before the verdict; it outlasts busy and the done strobe.
    localparam int SETTLE       = NUM_TIMERS + 6;
    localparam int PHASE_WORDS  = 185;
    localparam int NUM_PHASES   = 4;
    localparam int SEC_MAX      = (1 << SEC_W) - 1;
    localparam int ID_MAX       = (1 << ID_W) - 1;
    localparam int MODE_MAX     = (1 << MODE_W) - 1;
    // Codes past query do nothing and answer zero.
    localparam int MODE_SPARE_LO = MODE_QUERY + 1;
    localparam logic [ID_W-1:0] NO_TIMER = '0;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_done;
    t_cmd_word i_cmd;
    t_rsp_word o_rsp;

    int errors;
    int outstanding;
    int checked;
    int fired;
    int overdue;
    int words_sent;
    // Chance, in percent, that the sender leaves a cycle empty after a word.
    int idle_pct;

    multi_interval_timer #(
        .NUM_TIMERS(NUM_TIMERS),
        .TIME_WIDTH(TIME_WIDTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_cmd  (i_cmd),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    mit_resp_checker #(
        .NUM_TIMERS(NUM_TIMERS),
        .TIME_WIDTH(TIME_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .o_errors     (errors),
        .o_outstanding(outstanding),
        .o_checked    (checked),
        .o_fired      (fired),
        .o_overdue    (overdue)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (~1k words plus sender gaps) is far
    // below this.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drives one word and returns once the block has taken it. Start stays
    // high across back-to-back words, so no edge ever sees it dropped and
    // raised in the same step. Sender gaps follow the acceptance edge.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                             input logic [SEC_W-1:0] secs);
        t_cmd_word w;
        w.mode     = mode;
        w.timer_id = id;
        w.seconds  = secs;
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        words_sent++;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every pending response has come back.
    // The first edge lets the checker register the last accepted word.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: lots of ticks so short timers actually
    // run out, starts with small intervals, checks and queries; a slice of
    // raw noise covers id 0, the spare mode codes and every seconds bit.
    task automatic random_word();
        int                pick;
        logic [ID_W-1:0]   id;
        logic [SEC_W-1:0]  secs;
        pick = $urandom_range(99);
        id   = ID_W'($urandom_range(ID_MAX));
        if ($urandom_range(9) < 7) begin
            secs = SEC_W'($urandom_range(12));
        end else if ($urandom_range(1) == 0) begin
            secs = SEC_W'($urandom_range(400));
        end else begin
            secs = SEC_W'($urandom_range(SEC_MAX));
        end
        if (pick < 36) begin
            send_word(MODE_TICK, id, secs);
        end else if (pick < 60) begin
            if (id == NO_TIMER && $urandom_range(9) != 0) begin
                id = ID_W'($urandom_range(1, ID_MAX));
            end
            send_word(MODE_START, id, secs);
        end else if (pick < 65) begin
            send_word(MODE_STOP, id, secs);
        end else if (pick < 80) begin
            send_word(MODE_CHECK, id, secs);
        end else if (pick < 94) begin
            send_word(MODE_QUERY, id, secs);
        end else begin
            send_word(MODE_W'($urandom_range(MODE_MAX)), id,
                      SEC_W'($urandom_range(SEC_MAX)));
        end
    endtask

    initial begin
        words_sent = 0;
        idle_pct   = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: idle bank, id 0, extremes of seconds, zero-length
        // timers, equal expiries, restart of a running timer, stop of an idle
        // timer, overdue queries and the spare mode codes.
        send_word(MODE_QUERY, 3'd3, '0);
        send_word(MODE_CHECK, NO_TIMER, '0);
        send_word(MODE_START, NO_TIMER, 16'd5);
        send_word(MODE_QUERY, NO_TIMER, '0);
        send_word(MODE_START, 3'd7, SEC_W'(SEC_MAX));
        send_word(MODE_START, 3'd1, '0);
        send_word(MODE_CHECK, NO_TIMER, '0);        // timer 1 due at once
        send_word(MODE_START, 3'd2, 16'd2);
        send_word(MODE_START, 3'd3, 16'd2);         // tie with 2, lower id wins
        send_word(MODE_START, 3'd2, 16'd5);         // restart moves 2 later
        send_word(MODE_QUERY, 3'd2, '0);
        send_word(MODE_STOP, 3'd4, '0);             // already idle
        send_word(MODE_STOP, NO_TIMER, '0);
        send_word(MODE_TICK, NO_TIMER, '0);
        send_word(MODE_TICK, 3'd5, SEC_W'(SEC_MAX));
        send_word(MODE_CHECK, NO_TIMER, '0);        // expect 3
        send_word(MODE_CHECK, NO_TIMER, '0);        // 2 not yet due
        send_word(MODE_QUERY, 3'd7, '0);
        for (int m = MODE_SPARE_LO; m <= MODE_MAX; m++) begin
            send_word(MODE_W'(m), 3'd2, SEC_W'(SEC_MAX));
        end
        repeat (4) send_word(MODE_TICK, NO_TIMER, '0);
        send_word(MODE_QUERY, 3'd2, '0);            // past due, negative
        send_word(MODE_CHECK, NO_TIMER, '0);        // expect 2
        drain();

        // Random phases: back to back, sender mostly idle, back to back
        // again, then light idling; a full drain separates each phase.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1:       idle_pct = 76;
                3:       idle_pct = 31;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                random_word();
            end
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d command words over %0d pacing phases; %0d responses compared.",
                 words_sent, NUM_PHASES, checked);
        $display("Timers fired on check: %0d; queries answered past due: %0d.",
                 fired, overdue);
        if (errors == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
